>>> rtl/core/sv39ptm_pkg.sv
// ----------------------------------------------------------------------------
// sv39ptm_pkg
// Shared types and constants for the Sv39 page table map engine.
// ----------------------------------------------------------------------------
package sv39ptm_pkg;

  // operation codes
  localparam logic [2:0] OP_MAP   = 3'd0;
  localparam logic [2:0] OP_SETF  = 3'd1;
  localparam logic [2:0] OP_CHECK = 3'd2;
  localparam logic [2:0] OP_FAULT = 3'd3;
  localparam logic [2:0] OP_FREE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_NOMAP  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ROOT_FRAME   = 3'd0;
  localparam logic [2:0] CFG_RAM_BASE     = 3'd1;
  localparam logic [2:0] CFG_DIRECT_LIMIT = 3'd2;
  localparam logic [2:0] CFG_USER_START   = 3'd3;
  localparam logic [2:0] CFG_USER_END     = 3'd4;

  // configuration reset values
  localparam logic [3:0]  RST_ROOT_FRAME   = 4'd0;
  localparam logic [43:0] RST_RAM_BASE     = 44'd524288;
  localparam logic [26:0] RST_DIRECT_LIMIT = 27'd524800;
  localparam logic [26:0] RST_USER_START   = 27'd0;
  localparam logic [26:0] RST_USER_END     = 27'h7FFFFFF;

  // PTE flag constants
  localparam logic [7:0] LEAF_EXTRA  = 8'hC1;  // A | D | V
  localparam logic [7:0] FAULT_FLAGS = 8'h17;  // R | W | U | V
  localparam logic [9:0] TABLE_FLAGS = 10'h001;

  localparam int unsigned MAX_CHECK = 4096;

  typedef struct packed {
    logic [3:0]  root_frame;
    logic [43:0] ram_base_ppn;
    logic [26:0] direct_limit_vpn;
    logic [26:0] user_start_vpn;
    logic [26:0] user_end_vpn;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [43:0] leaf_ppn;
  } res_t;

endpackage

>>> rtl/core/sv39ptm_ram.sv
// ----------------------------------------------------------------------------
// sv39ptm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sv39ptm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sv39ptm_seq.sv
// ----------------------------------------------------------------------------
// sv39ptm_seq
// Operation sequencer: walks, allocates, clears and writes the PTE store and
// the free frame stack, one operation at a time.
// ----------------------------------------------------------------------------
module sv39ptm_seq #(
  parameter int unsigned POOL_FRAMES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sv39ptm_pkg::cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic [63:0]        vaddr_i,
  input  logic [7:0]         perm_flags_i,
  input  logic [12:0]        check_pages_i,
  input  logic [43:0]        frame_ppn_i,
  input  logic               res_room_i,
  output logic               res_valid_o,
  output sv39ptm_pkg::res_t  res_o
);
  import sv39ptm_pkg::*;

  localparam int unsigned FW    = $clog2(POOL_FRAMES);
  localparam int unsigned AW    = FW + 9;
  localparam int unsigned DEPTH = POOL_FRAMES * 512;
  localparam int unsigned CW    = $clog2(POOL_FRAMES + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_ROOT, S_L2, S_L1, S_LEAF, S_NEED,
    S_POP, S_TAKE, S_CLR, S_LINK, S_WLEAF, S_DONE
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   init_cnt_q;
  logic [CW-1:0]   count_q;
  logic [2:0]      op_q;
  logic [51:0]     vpn_q;
  logic [51:0]     cur_vpn_q;
  logic [7:0]      perm_q;
  logic [7:0]      flags_q;
  logic [12:0]     pages_q;
  logic [43:0]     fppn_q;
  logic            fresh_q, v2_q, v1_q;
  logic            need_leaf_q, need_t1_q, need_t0_q;
  logic [FW-1:0]   f1_q, f0_q, clr_frame_q;
  logic [8:0]      clr_cnt_q;
  logic [43:0]     ppn_q;
  logic [1:0]      status_q;
  logic [43:0]     leaf_q;

  // memory ports
  logic            st_we;
  logic [AW-1:0]   st_waddr, st_raddr;
  logic [63:0]     st_wdata, st_rdata;
  logic            sk_we;
  logic [FW-1:0]   sk_waddr, sk_raddr, sk_wdata, sk_rdata;

  sv39ptm_ram #(.Width(64), .Depth(DEPTH)) u_pte_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  sv39ptm_ram #(.Width(FW), .Depth(POOL_FRAMES)) u_stack_ram (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .raddr_i(sk_raddr), .rdata_o(sk_rdata)
  );

  // entry decode of the word just read
  logic [43:0]   e_ppn, e_diff, f_diff;
  logic          e_ok, root_bad, free_ok;
  logic [FW-1:0] e_fr, root_fr;
  logic [8:0]    idx2, idx1, idx0;
  logic [1:0]    need;
  logic [43:0]   ptr_ppn;

  assign e_ppn    = st_rdata[53:10];
  assign e_diff   = e_ppn - cfg_i.ram_base_ppn;
  assign e_ok     = (e_ppn >= cfg_i.ram_base_ppn) && (e_diff < 44'(POOL_FRAMES));
  assign e_fr     = e_diff[FW-1:0];
  assign root_bad = 32'(cfg_i.root_frame) >= 32'(POOL_FRAMES);
  assign root_fr  = FW'(cfg_i.root_frame);
  assign f_diff   = fppn_q - cfg_i.ram_base_ppn;
  assign free_ok  = (fppn_q >= cfg_i.ram_base_ppn) && (f_diff < 44'(POOL_FRAMES)) &&
                    (32'(count_q) < 32'(POOL_FRAMES));
  assign idx2     = cur_vpn_q[26:18];
  assign idx1     = cur_vpn_q[17:9];
  assign idx0     = cur_vpn_q[8:0];
  assign need     = 2'(fresh_q) + 2'(!v2_q) + 2'(!v1_q);
  assign ptr_ppn  = cfg_i.ram_base_ppn + 44'(clr_frame_q);

  // memory port control
  always_comb begin
    st_we    = 1'b0;
    st_waddr = {root_fr, idx2};
    st_wdata = '0;
    st_raddr = {root_fr, idx2};
    sk_we    = 1'b0;
    sk_waddr = count_q[FW-1:0];
    sk_wdata = f_diff[FW-1:0];
    sk_raddr = FW'(count_q - 1'b1);
    unique case (state_q)
      S_INIT: begin
        st_we    = 1'b1;
        st_waddr = init_cnt_q;
        if (init_cnt_q < AW'(POOL_FRAMES)) begin
          sk_we    = 1'b1;
          sk_waddr = init_cnt_q[FW-1:0];
          sk_wdata = (init_cnt_q[FW-1:0] == FW'(POOL_FRAMES - 1)) ? '0
                     : init_cnt_q[FW-1:0] + 1'b1;
        end
      end
      S_DISP: sk_we = (op_q == OP_FREE) && free_ok;
      S_L2:   st_raddr = {e_fr, idx1};
      S_L1:   st_raddr = {e_fr, idx0};
      S_LEAF: begin
        st_we    = (op_q == OP_SETF);
        st_waddr = {f0_q, idx0};
        st_wdata = {st_rdata[63:8], flags_q};
      end
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = {clr_frame_q, clr_cnt_q};
      end
      S_LINK: begin
        st_we    = 1'b1;
        st_waddr = need_t1_q ? {root_fr, idx2} : {f1_q, idx1};
        st_wdata = {10'd0, ptr_ppn, TABLE_FLAGS};
      end
      S_WLEAF: begin
        st_we    = 1'b1;
        st_waddr = {f0_q, idx0};
        st_wdata = {10'd0, ppn_q, 2'b00, flags_q};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      count_q     <= CW'(POOL_FRAMES - 1);
      need_leaf_q <= 1'b0;
      need_t1_q   <= 1'b0;
      need_t0_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_INIT: begin
          init_cnt_q <= init_cnt_q + 1'b1;
          if (init_cnt_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= op_i;
            vpn_q     <= vaddr_i[63:12];
            cur_vpn_q <= vaddr_i[63:12];
            perm_q    <= perm_flags_i;
            flags_q   <= (op_i == OP_FAULT) ? (FAULT_FLAGS | LEAF_EXTRA)
                                            : (perm_flags_i | LEAF_EXTRA);
            pages_q   <= (check_pages_i > 13'(MAX_CHECK)) ? 13'(MAX_CHECK) : check_pages_i;
            fppn_q    <= frame_ppn_i;
            state_q   <= S_DISP;
          end
        end
        S_DISP: begin
          status_q <= ST_OK;
          leaf_q   <= '0;
          v2_q     <= 1'b1;
          v1_q     <= 1'b1;
          unique case (op_q)
            OP_MAP: begin
              fresh_q <= vpn_q >= 52'(cfg_i.direct_limit_vpn);
              state_q <= S_ROOT;
            end
            OP_SETF: state_q <= S_ROOT;
            OP_CHECK: state_q <= (pages_q == '0) ? S_DONE : S_ROOT;
            OP_FAULT: begin
              fresh_q <= 1'b1;
              if (vpn_q >= 52'(cfg_i.user_start_vpn) && vpn_q < 52'(cfg_i.user_end_vpn) &&
                  (vpn_q[51:26] == '0 || vpn_q[51:26] == '1)) begin
                state_q <= S_ROOT;
              end else begin
                status_q <= ST_REJECT;
                state_q  <= S_DONE;
              end
            end
            OP_FREE: begin
              if (free_ok) count_q <= count_q + 1'b1;
              else status_q <= ST_NOMAP;
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_ROOT: begin
          if (root_bad) begin
            status_q <= ST_NOMAP;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_L2;
          end
        end
        S_L2: begin
          f1_q <= e_fr;
          if (op_q == OP_MAP || op_q == OP_FAULT) begin
            v2_q <= st_rdata[0];
            if (!st_rdata[0]) begin
              v1_q    <= 1'b0;
              state_q <= S_NEED;
            end else if (!e_ok) begin
              status_q <= ST_NOMAP;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_L1;
            end
          end else if (!st_rdata[0] || !e_ok) begin
            status_q <= ST_NOMAP;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_L1;
          end
        end
        S_L1: begin
          f0_q <= e_fr;
          if (op_q == OP_MAP || op_q == OP_FAULT) begin
            v1_q <= st_rdata[0];
            if (st_rdata[0] && !e_ok) begin
              status_q <= ST_NOMAP;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_NEED;
            end
          end else if (!st_rdata[0] || !e_ok) begin
            status_q <= ST_NOMAP;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_LEAF;
          end
        end
        S_LEAF: begin
          if (op_q == OP_SETF) begin
            state_q <= S_DONE;
          end else if ((st_rdata[7:0] & perm_q) == '0) begin
            status_q <= ST_NOMAP;
            state_q  <= S_DONE;
          end else if (pages_q == 13'd1) begin
            state_q <= S_DONE;
          end else begin
            pages_q   <= pages_q - 1'b1;
            cur_vpn_q <= cur_vpn_q + 1'b1;
            state_q   <= S_ROOT;
          end
        end
        S_NEED: begin
          need_leaf_q <= fresh_q;
          need_t1_q   <= !v2_q;
          need_t0_q   <= !v1_q;
          ppn_q       <= vpn_q[43:0];
          if (32'(count_q) < 32'(need)) begin
            status_q <= ST_OOM;
            state_q  <= S_DONE;
          end else if (need != '0) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_WLEAF;
          end
        end
        S_POP: begin
          count_q <= count_q - 1'b1;
          state_q <= S_TAKE;
        end
        S_TAKE: begin
          if (need_leaf_q) begin
            ppn_q       <= cfg_i.ram_base_ppn + 44'(sk_rdata);
            need_leaf_q <= 1'b0;
            state_q     <= (need_t1_q || need_t0_q) ? S_POP : S_WLEAF;
          end else begin
            clr_frame_q <= sk_rdata;
            clr_cnt_q   <= '0;
            if (need_t1_q) f1_q <= sk_rdata;
            else f0_q <= sk_rdata;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == 9'h1FF) state_q <= S_LINK;
        end
        S_LINK: begin
          if (need_t1_q) begin
            need_t1_q <= 1'b0;
            state_q   <= S_POP;
          end else begin
            need_t0_q <= 1'b0;
            state_q   <= S_WLEAF;
          end
        end
        S_WLEAF: begin
          leaf_q  <= ppn_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_room_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE) && res_room_i;
  assign res_o.status   = status_q;
  assign res_o.leaf_ppn = (status_q == ST_OK) ? leaf_q : '0;

endmodule

>>> rtl/core/sv39_page_table_map_engine_core.sv
// ----------------------------------------------------------------------------
// sv39_page_table_map_engine_core
// Sv39 page table map engine: map, set flags, check, page fault, free frame.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, one beat per operation; each gives
//   exactly one result beat on m_axis (status and leaf PPN). Configuration
//   registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i while
//   the engine is idle.
//   One operation is in flight at a time. Work per command:
//     set flags: three table reads, one write
//     check: three dependent reads of the PTE RAM per page
//     map / fault: 512 clear writes for each new table, all through the
//     single PTE RAM write port
//   The PTE RAM and the free stack RAM are each one-read, one-write.
//   After reset a clearing pass writes every PTE entry and loads the free
//   stack, with s_axis_tready low.
//   The result sits in an output register; the next command is taken while
//   it waits, and a finished operation only waits if that register is full.
// ----------------------------------------------------------------------------
module sv39_page_table_map_engine_core #(
  parameter int unsigned POOL_FRAMES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [43:0]  cfg_wdata_i,
  // command stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] op, [66:3] vaddr, [74:67] perm_flags, [87:75] check_pages,
  // [131:88] frame_ppn, [135:132] zero
  input  logic [135:0] s_axis_tdata,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [45:2] leaf_ppn, [47:46] zero
  output logic [47:0]  m_axis_tdata
);
  import sv39ptm_pkg::*;

  cfg_t cfg_q;
  res_t res;
  logic res_valid, res_room;
  logic out_valid_q;
  res_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_frame       <= RST_ROOT_FRAME;
      cfg_q.ram_base_ppn     <= RST_RAM_BASE;
      cfg_q.direct_limit_vpn <= RST_DIRECT_LIMIT;
      cfg_q.user_start_vpn   <= RST_USER_START;
      cfg_q.user_end_vpn     <= RST_USER_END;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROOT_FRAME:   cfg_q.root_frame       <= cfg_wdata_i[3:0];
        CFG_RAM_BASE:     cfg_q.ram_base_ppn     <= cfg_wdata_i;
        CFG_DIRECT_LIMIT: cfg_q.direct_limit_vpn <= cfg_wdata_i[26:0];
        CFG_USER_START:   cfg_q.user_start_vpn   <= cfg_wdata_i[26:0];
        CFG_USER_END:     cfg_q.user_end_vpn     <= cfg_wdata_i[26:0];
        default: ;
      endcase
    end
  end

  sv39ptm_seq #(.POOL_FRAMES(POOL_FRAMES)) u_seq (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tdata[2:0]),
    .vaddr_i      (s_axis_tdata[66:3]),
    .perm_flags_i (s_axis_tdata[74:67]),
    .check_pages_i(s_axis_tdata[87:75]),
    .frame_ppn_i  (s_axis_tdata[131:88]),
    .res_room_i   (res_room),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register
  assign res_room = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.leaf_ppn, out_q.status};

  // checks
  a_handoff_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result handed off with output register full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command taken while another is in flight");

  a_fail_no_ppn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[45:2] == '0))
    else $error("failed result carries a leaf PPN");

endmodule
